// ----- sv/assert_macros.svh -----
// assertion macros shared by the peak index search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define PIBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition followed in the next cycle by a property, disabled during reset
`define PIBS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- sv/pibs_pkg.sv -----
// shared types and constants of the peak index search block
package pibs_pkg;

   localparam int VALUE_BITS = 64;
   localparam int PEAK_BITS  = 10;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [PEAK_BITS-1:0]         peak_type;

   typedef struct packed {
      peak_type peak_index;
      logic     overflow;
   } res_type;

endpackage

// ----- sv/pibs_if.sv -----
// valid/ready channel interfaces for element and result transactions
interface pibs_req_if;
   import pibs_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface pibs_rsp_if;
   import pibs_pkg::*;

   logic     valid;
   logic     ready;
   peak_type peak_index;
   logic     overflow;

   modport source (output valid, output peak_index, output overflow, input ready);
   modport sink (input valid, input peak_index, input overflow, output ready);
endinterface

// ----- sv/pibs_store.sv -----
// element memory: one write port, two registered read ports
module pibs_store #(
   parameter int DEPTH       = 1024,
   parameter int VALUE_WIDTH = 64,
   localparam int AW         = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr_a,
   input  logic [AW-1:0]                 rd_addr_b,
   output logic signed [VALUE_WIDTH-1:0] rd_data_a,
   output logic signed [VALUE_WIDTH-1:0] rd_data_b
);

   logic signed [VALUE_WIDTH-1:0] mem_array [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_array[rd_addr_a];
      rd_data_b <= mem_array[rd_addr_b];
   end

endmodule

// ----- sv/pibs_ctrl.sv -----
// loading of elements and binary search sequencer over the element memory
`include "assert_macros.svh"

module pibs_ctrl #(
   parameter int DEPTH       = 1024,
   parameter int VALUE_WIDTH = 64,
   localparam int AW         = $clog2(DEPTH),
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int SW         = AW + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   pibs_req_if.sink                      req,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic signed [VALUE_WIDTH-1:0] wr_data,
   output logic [AW-1:0]                 rd_addr_a,
   output logic [AW-1:0]                 rd_addr_b,
   input  logic signed [VALUE_WIDTH-1:0] rd_data_a,
   input  logic signed [VALUE_WIDTH-1:0] rd_data_b,
   output logic                          res_valid,
   input  logic                          res_ready,
   output pibs_pkg::res_type             res
);
   import pibs_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_READ,
      S_CMP,
      S_FINAL_READ,
      S_FINAL_CMP,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW:0]   width_ff, width_in;
   logic          ok_ff, ok_in;
   res_type       res_ff, res_in;

   logic          full;
   logic [CW-1:0] n_cur;
   logic          drop_cur;
   logic [AW:0]   half;
   logic [SW-1:0] sum_a;
   logic [SW-1:0] sum_b;
   logic [SW-1:0] start_inc;
   logic          less;

   assign full      = (count_ff == CW'(DEPTH));
   assign n_cur     = full ? count_ff : count_ff + CW'(1);
   assign drop_cur  = dropped_ff | full;
   assign half      = width_ff >> 1;
   assign sum_a     = SW'(start_ff) + SW'(half);
   assign sum_b     = sum_a + SW'(1);
   assign start_inc = SW'(start_ff) + SW'(1);
   assign less      = (rd_data_a < rd_data_b);

   assign req.ready = (state_ff == S_LOAD);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;
   assign wr_addr   = count_ff[AW-1:0];
   assign wr_data   = req.value[VALUE_WIDTH-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      start_in   = start_ff;
      width_in   = width_ff;
      ok_in      = ok_ff;
      res_in     = res_ff;
      wr_en      = 1'b0;
      rd_addr_a  = sum_a[AW-1:0];
      rd_addr_b  = sum_b[AW-1:0];
      case (state_ff)
         S_LOAD: begin
            if (req.valid) begin
               wr_en      = !full;
               count_in   = n_cur;
               dropped_in = drop_cur;
               if (req.last) begin
                  count_in          = '0;
                  dropped_in        = 1'b0;
                  n_in              = n_cur;
                  start_in          = '0;
                  width_in          = {1'b1, {AW{1'b0}}};
                  res_in.overflow   = drop_cur;
                  res_in.peak_index = '0;
                  if (n_cur <= CW'(1)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            width_in = half;
            ok_in    = (sum_b < SW'(n_ff));
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ok_ff && less) begin
               start_in = start_ff + AW'(width_ff);
            end
            if (width_ff > (AW+1)'(1)) begin
               state_in = S_READ;
            end else begin
               state_in = S_FINAL_READ;
            end
         end
         S_FINAL_READ: begin
            rd_addr_a = start_ff;
            rd_addr_b = start_inc[AW-1:0];
            state_in  = S_FINAL_CMP;
         end
         S_FINAL_CMP: begin
            if (less) begin
               res_in.peak_index = peak_type'(start_inc);
            end else begin
               res_in.peak_index = peak_type'(start_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
      n_ff     <= n_in;
      start_ff <= start_in;
      width_ff <= width_in;
      ok_ff    <= ok_in;
      res_ff   <= res_in;
   end

   `PIBS_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "loaded count beyond depth")
   `PIBS_ASSERT(a_start_bound, (state_ff != S_LOAD && state_ff != S_DONE) |-> (start_inc < SW'(n_ff)), "search start out of set")
   `PIBS_ASSERT_NEXT(a_search_entry, state_ff == S_LOAD && req.valid && req.last, state_ff == S_READ || state_ff == S_DONE, "closing transaction did not start search")

endmodule

// ----- sv/peak_index_binary_search.sv -----
// top level of the local peak index search block
//
// req channel: one signed element per transaction (value, last). Elements are
// written to the element memory at one per cycle. The transaction with last
// set closes the set; further elements beyond DEPTH are dropped and reported.
// rsp channel: one transaction per closed set carrying peak_index and overflow.
// Search: each halving round over a window of 2**clog2(DEPTH) entries reads a
// pair of neighbouring elements (S_READ) and compares them (S_CMP); a final
// read and compare of the pair at the window start gives the result. A
// one-element set goes to the result without a search.
// Throughput: one element per cycle while loading; req.ready stays low during
// the search and while the result waits to enter the output register.
// The result sits in an output register, so loading of the next set goes on
// while rsp is stalled; a second result waits until that register is free.
// Reset is synchronous: it empties the current set and drops any pending
// result; memory contents are not cleared.
module peak_index_binary_search #(
   parameter int DEPTH       = 1024,
   parameter int VALUE_WIDTH = 64
) (
   input logic        clock,
   input logic        reset,
   pibs_req_if.sink   req,
   pibs_rsp_if.source rsp
);
   import pibs_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]                 rd_addr_a;
   logic [AW-1:0]                 rd_addr_b;
   logic signed [VALUE_WIDTH-1:0] rd_data_a;
   logic signed [VALUE_WIDTH-1:0] rd_data_b;
   logic                          res_valid;
   logic                          res_ready;
   res_type                       res;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;

   pibs_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   pibs_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register, free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.peak_index = rsp_res_ff.peak_index;
   assign rsp.overflow   = rsp_res_ff.overflow;

endmodule
